FILE: rtl/assert_macros.svh
// Assertion macros for the pointer event tracker RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PET_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pointer event tracker assertion failed");
`define PET_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("pointer event tracker forbidden condition seen");
`else
`define PET_ASSERT(lbl, clk, rstn, prop)
`define PET_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

FILE: rtl/pet_pkg.sv
// Shared types and constants for the pointer event tracker.
// Used by pet_alu, pet_seq and pointer_event_tracker_top; no dependencies.
package pet_pkg;

  localparam int unsigned CoordBitsDef = 13;

  localparam int unsigned AluW  = 64;
  localparam int unsigned StepW = 7;
  localparam int unsigned DeltaW = 54;

  localparam int unsigned SizeW  = 14;
  localparam int unsigned ResW   = 16;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TpmW   = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  localparam int unsigned TickScale  = 1000;
  localparam int unsigned SpeedShift = 10;

  // floor(x / 1000) equals (x * TickRecip) >> TickRecipShift for any 32-bit x
  localparam logic [AluW-1:0] TickRecip      = 64'd274877907;
  localparam int unsigned     TickRecipShift = 38;

  localparam int unsigned MulSizeSteps  = SizeW;
  localparam int unsigned MulSpeedSteps = SpeedW;
  localparam int unsigned MulTpmSteps   = TpmW;
  localparam int unsigned DivElpSteps   = AluW;
  localparam int unsigned DivMoveSteps  = 46;

  localparam logic [SizeW-1:0]  ScreenWidthRst  = 14'd1024;
  localparam logic [SizeW-1:0]  ScreenHeightRst = 14'd768;
  localparam logic [ResW-1:0]   ResolutionRst   = 16'd1;
  localparam logic [SpeedW-1:0] SpeedRst        = 16'd2;
  localparam logic [MsW-1:0]    DoubleClickRst  = 16'd500;
  localparam logic [TpmW-1:0]   TicksPerMsRst   = 32'd1000000;
  localparam int unsigned       CursorXRst      = 256;
  localparam int unsigned       CursorYRst      = 192;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_LEFT_DOWN    = 4'd1,
    EV_RIGHT_DOWN   = 4'd2,
    EV_LEFT_CLICK   = 4'd3,
    EV_DOUBLE_CLICK = 4'd4,
    EV_RIGHT_CLICK  = 4'd5,
    EV_SCROLL_DOWN  = 4'd6,
    EV_SCROLL_UP    = 4'd7,
    EV_MOVE         = 4'd8
  } pet_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_RESOLUTION_X  = 3'd2,
    REG_RESOLUTION_Y  = 3'd3,
    REG_POINTER_SPEED = 3'd4,
    REG_MIRROR_X      = 3'd5,
    REG_DOUBLE_CLICK  = 3'd6,
    REG_TICKS_PER_MS  = 3'd7
  } pet_reg_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } pet_alu_op_e;

  typedef enum logic [1:0] {
    WHEEL_NONE = 2'd0,
    WHEEL_POS  = 2'd1,
    WHEEL_NEG  = 2'd2
  } pet_wheel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TPM_GO,
    S_TPM_WAIT,
    S_ELP_GO,
    S_ELP_WAIT,
    S_AXIS,
    S_M1_GO,
    S_M1_WAIT,
    S_DV_GO,
    S_DV_WAIT,
    S_M2_GO,
    S_M2_WAIT,
    S_UPD,
    S_OUT
  } pet_state_e;

  typedef struct packed {
    logic [SizeW-1:0]  screen_width;
    logic [SizeW-1:0]  screen_height;
    logic [ResW-1:0]   resolution_x;
    logic [ResW-1:0]   resolution_y;
    logic [SpeedW-1:0] pointer_speed;
    logic              mirror_x;
    logic [MsW-1:0]    double_click_ms;
    logic [TpmW-1:0]   ticks_per_ms;
  } pet_cfg_t;

  typedef struct packed {
    logic             start;
    pet_alu_op_e      op;
    logic [StepW-1:0] steps;
    logic [AluW-1:0]  a;
    logic [AluW-1:0]  b;
  } pet_alu_req_t;

  typedef struct packed {
    logic            busy;
    logic [AluW-1:0] r;
    logic [AluW-1:0] q;
  } pet_alu_rsp_t;

endpackage

FILE: rtl/pet_alu.sv
// Shared shift-add multiplier / restoring divider, one bit per cycle.
// Depends on pet_pkg for the request and response types.
module pet_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pet_pkg::pet_alu_req_t req_i,
  output pet_pkg::pet_alu_rsp_t rsp_o
);

  logic [pet_pkg::AluW-1:0]  r_q, q_q, b_q;
  logic [pet_pkg::StepW-1:0] cnt_q;
  pet_pkg::pet_alu_op_e      op_q;

  logic [pet_pkg::AluW:0]    rs;
  logic [pet_pkg::AluW+1:0]  trial;
  logic                      ge;
  logic [pet_pkg::AluW-1:0]  mul_sum;

  always_comb begin
    rs      = {r_q, q_q[pet_pkg::AluW-1]};
    trial   = {1'b0, rs} - {2'b00, b_q};
    ge      = ~trial[pet_pkg::AluW+1];
    mul_sum = {r_q[pet_pkg::AluW-2:0], 1'b0} + (q_q[pet_pkg::AluW-1] ? b_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      op_q  <= pet_pkg::ALU_MUL;
    end else if (req_i.start) begin
      cnt_q <= req_i.steps;
      op_q  <= req_i.op;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - pet_pkg::StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= '0;
      q_q <= req_i.a;
      b_q <= req_i.b;
    end else if (cnt_q != '0) begin
      if (op_q == pet_pkg::ALU_DIV) begin
        r_q <= ge ? trial[pet_pkg::AluW-1:0] : rs[pet_pkg::AluW-1:0];
        q_q <= {q_q[pet_pkg::AluW-2:0], ge};
      end else begin
        r_q <= mul_sum;
        q_q <= {q_q[pet_pkg::AluW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.r    = r_q;
  assign rsp_o.q    = q_q;

endmodule

FILE: rtl/pet_seq.sv
// Sequencer: event classification, scaling steps on the shared unit, cursor clamp.
// Depends on pet_pkg; drives pet_alu through pet_alu_req_t.
module pet_seq #(
  parameter int unsigned CoordBits = pet_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pet_pkg::pet_cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_read_ok_i,
  input  logic                  in_left_i,
  input  logic                  in_right_i,
  input  logic signed [31:0]    in_mx_i,
  input  logic signed [31:0]    in_my_i,
  input  logic signed [31:0]    in_mz_i,
  input  logic [63:0]           in_now_i,
  output pet_pkg::pet_alu_req_t alu_req_o,
  input  pet_pkg::pet_alu_rsp_t alu_rsp_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output pet_pkg::pet_event_e   res_event_o,
  output logic [CoordBits-1:0]  res_pos_x_o,
  output logic [CoordBits-1:0]  res_pos_y_o
);

  localparam int unsigned SumW = pet_pkg::DeltaW + 1;
  localparam logic [16:0] CoordMax = 17'((1 << CoordBits) - 1);

  pet_pkg::pet_state_e state_q, state_d;
  logic                left_prev_q, left_prev_d;
  logic                right_prev_q, right_prev_d;
  pet_pkg::pet_wheel_e wheel_q, wheel_d;
  logic                moved_q, moved_d;
  logic [63:0]         last_click_q, last_click_d;
  logic [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic                axis_q, axis_d;

  pet_pkg::pet_event_e ev_q, ev_d;
  logic [63:0]         diff_q, diff_d;
  logic signed [31:0]  mx_q, mx_d, my_q, my_d;
  logic signed [pet_pkg::DeltaW-1:0] dx_q, dx_d, dy_q, dy_d;

  logic signed [31:0]  mv_sel;
  logic [31:0]         mv_mag;
  logic [pet_pkg::SizeW-1:0] size_sel;
  logic [pet_pkg::ResW-1:0]  res_sel;
  logic [61:0]         p_mag;
  logic [52:0]         d_mag;
  logic signed [pet_pkg::DeltaW-1:0] delta;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic                release_edge;

  function automatic logic [CoordBits-1:0] clamp_pos(input logic signed [SumW-1:0] pos,
                                                     input logic [pet_pkg::SizeW-1:0] size);
    logic [16:0]          lim;
    logic [CoordBits-1:0] res;
    lim = 17'(size) - 17'd1;
    if (lim > CoordMax) begin
      lim = CoordMax;
    end
    if (size == '0) begin
      res = '0;
    end else if (pos < 0) begin
      res = '0;
    end else if (pos > $signed({{(SumW-17){1'b0}}, lim})) begin
      res = lim[CoordBits-1:0];
    end else begin
      res = pos[CoordBits-1:0];
    end
    return res;
  endfunction

  always_comb begin
    mv_sel   = axis_q ? my_q : mx_q;
    mv_mag   = mv_sel[31] ? (~mv_sel + 32'd1) : mv_sel;
    size_sel = axis_q ? cfg_i.screen_height : cfg_i.screen_width;
    res_sel  = axis_q ? cfg_i.resolution_y : cfg_i.resolution_x;
    p_mag    = alu_rsp_i.r[61:0];
    d_mag    = {1'b0, p_mag[61:pet_pkg::SpeedShift]}
             + 53'(mv_sel[31] && (p_mag[pet_pkg::SpeedShift-1:0] != '0));
    delta    = mv_sel[31] ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
    sum_x    = cfg_i.mirror_x
             ? $signed({{(SumW-CoordBits){1'b0}}, cur_x_q}) - SumW'(dx_q)
             : $signed({{(SumW-CoordBits){1'b0}}, cur_x_q}) + SumW'(dx_q);
    sum_y    = $signed({{(SumW-CoordBits){1'b0}}, cur_y_q}) + SumW'(dy_q);
  end

  always_comb begin
    state_d      = state_q;
    left_prev_d  = left_prev_q;
    right_prev_d = right_prev_q;
    wheel_d      = wheel_q;
    moved_d      = moved_q;
    last_click_d = last_click_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    axis_d       = axis_q;
    ev_d         = ev_q;
    diff_d       = diff_q;
    mx_d         = mx_q;
    my_d         = my_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    release_edge = 1'b0;
    alu_req_o    = '0;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      pet_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_read_ok_i) begin
          priority if (!left_prev_q && in_left_i) begin
            ev_d = pet_pkg::EV_LEFT_DOWN;
          end else if (!right_prev_q && in_right_i) begin
            ev_d = pet_pkg::EV_RIGHT_DOWN;
          end else if (left_prev_q && !in_left_i) begin
            ev_d         = pet_pkg::EV_LEFT_CLICK;
            release_edge = 1'b1;
          end else if (right_prev_q && !in_right_i) begin
            ev_d = pet_pkg::EV_RIGHT_CLICK;
          end else if (wheel_q == pet_pkg::WHEEL_POS) begin
            ev_d = pet_pkg::EV_SCROLL_DOWN;
          end else if (wheel_q == pet_pkg::WHEEL_NEG) begin
            ev_d = pet_pkg::EV_SCROLL_UP;
          end else if (moved_q) begin
            ev_d = pet_pkg::EV_MOVE;
          end else begin
            ev_d = pet_pkg::EV_NONE;
          end
          left_prev_d  = in_left_i;
          right_prev_d = in_right_i;
          wheel_d      = (in_mz_i > 0) ? pet_pkg::WHEEL_POS
                       : ((in_mz_i < 0) ? pet_pkg::WHEEL_NEG : pet_pkg::WHEEL_NONE);
          moved_d      = (in_mx_i != 0) || (in_my_i != 0);
          diff_d       = in_now_i - last_click_q;
          if (release_edge) begin
            last_click_d = in_now_i;
          end
          mx_d    = in_mx_i;
          my_d    = in_my_i;
          axis_d  = 1'b0;
          state_d = release_edge ? pet_pkg::S_TPM_GO : pet_pkg::S_AXIS;
        end
      end
      pet_pkg::S_TPM_GO: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = pet_pkg::ALU_MUL;
        alu_req_o.steps = pet_pkg::StepW'(pet_pkg::MulTpmSteps);
        alu_req_o.a     = {cfg_i.ticks_per_ms, 32'd0};
        alu_req_o.b     = pet_pkg::TickRecip;
        state_d         = pet_pkg::S_TPM_WAIT;
      end
      pet_pkg::S_TPM_WAIT: begin
        if (!alu_rsp_i.busy) begin
          state_d = (alu_rsp_i.r[pet_pkg::AluW-1:pet_pkg::TickRecipShift] == '0)
                  ? pet_pkg::S_AXIS : pet_pkg::S_ELP_GO;
        end
      end
      pet_pkg::S_ELP_GO: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = pet_pkg::ALU_DIV;
        alu_req_o.steps = pet_pkg::StepW'(pet_pkg::DivElpSteps);
        alu_req_o.a     = diff_q;
        alu_req_o.b     = {{pet_pkg::TickRecipShift{1'b0}},
                           alu_rsp_i.r[pet_pkg::AluW-1:pet_pkg::TickRecipShift]};
        state_d         = pet_pkg::S_ELP_WAIT;
      end
      pet_pkg::S_ELP_WAIT: begin
        if (!alu_rsp_i.busy) begin
          if (alu_rsp_i.q < {48'd0, cfg_i.double_click_ms}) begin
            ev_d = pet_pkg::EV_DOUBLE_CLICK;
          end
          state_d = pet_pkg::S_AXIS;
        end
      end
      pet_pkg::S_AXIS: begin
        if (res_sel == '0) begin
          if (axis_q) begin
            dy_d    = '0;
            state_d = pet_pkg::S_UPD;
          end else begin
            dx_d   = '0;
            axis_d = 1'b1;
          end
        end else begin
          state_d = pet_pkg::S_M1_GO;
        end
      end
      pet_pkg::S_M1_GO: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = pet_pkg::ALU_MUL;
        alu_req_o.steps = pet_pkg::StepW'(pet_pkg::MulSizeSteps);
        alu_req_o.a     = {size_sel, 50'd0};
        alu_req_o.b     = {32'd0, mv_mag};
        state_d         = pet_pkg::S_M1_WAIT;
      end
      pet_pkg::S_M1_WAIT: begin
        if (!alu_rsp_i.busy) begin
          state_d = pet_pkg::S_DV_GO;
        end
      end
      pet_pkg::S_DV_GO: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = pet_pkg::ALU_DIV;
        alu_req_o.steps = pet_pkg::StepW'(pet_pkg::DivMoveSteps);
        alu_req_o.a     = {alu_rsp_i.r[45:0], 18'd0};
        alu_req_o.b     = {48'd0, res_sel};
        state_d         = pet_pkg::S_DV_WAIT;
      end
      pet_pkg::S_DV_WAIT: begin
        if (!alu_rsp_i.busy) begin
          state_d = pet_pkg::S_M2_GO;
        end
      end
      pet_pkg::S_M2_GO: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = pet_pkg::ALU_MUL;
        alu_req_o.steps = pet_pkg::StepW'(pet_pkg::MulSpeedSteps);
        alu_req_o.a     = {cfg_i.pointer_speed, 48'd0};
        alu_req_o.b     = alu_rsp_i.q;
        state_d         = pet_pkg::S_M2_WAIT;
      end
      pet_pkg::S_M2_WAIT: begin
        if (!alu_rsp_i.busy) begin
          if (axis_q) begin
            dy_d    = delta;
            state_d = pet_pkg::S_UPD;
          end else begin
            dx_d    = delta;
            axis_d  = 1'b1;
            state_d = pet_pkg::S_AXIS;
          end
        end
      end
      pet_pkg::S_UPD: begin
        cur_x_d = clamp_pos(sum_x, cfg_i.screen_width);
        cur_y_d = clamp_pos(sum_y, cfg_i.screen_height);
        state_d = pet_pkg::S_OUT;
      end
      pet_pkg::S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = pet_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pet_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pet_pkg::S_IDLE;
      left_prev_q  <= 1'b0;
      right_prev_q <= 1'b0;
      wheel_q      <= pet_pkg::WHEEL_NONE;
      moved_q      <= 1'b0;
      last_click_q <= '0;
      cur_x_q      <= CoordBits'(pet_pkg::CursorXRst);
      cur_y_q      <= CoordBits'(pet_pkg::CursorYRst);
      axis_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      left_prev_q  <= left_prev_d;
      right_prev_q <= right_prev_d;
      wheel_q      <= wheel_d;
      moved_q      <= moved_d;
      last_click_q <= last_click_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      axis_q       <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    diff_q <= diff_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
  end

  assign res_event_o = ev_q;
  assign res_pos_x_o = cur_x_q;
  assign res_pos_y_o = cur_y_q;

endmodule

FILE: rtl/pointer_event_tracker_top.sv
// Pointer event tracker: one input word per device poll, one result word per good read.
// Slave channel s_axis (tuser = read_ok), master channel m_axis, plain config write port.
// A failed read (tuser low) is taken in the idle state and gives no result; the sequencer stays idle.
// A good read is classified at once, then X and Y movement are scaled on one
// shared shift-add / restoring-divide unit, one bit per cycle:
//   per axis 14 multiply steps, 46 divide steps, 16 multiply steps,
//   or none when that axis resolution is zero.
// A left release adds a 32-step multiply by the reciprocal of 1000 and a 64-step
// divide for elapsed time; the divide is skipped when ticks_per_ms is below 1000.
// s_axis_tready stays low from accept until the result goes to the output register.
// The result word sits in an output register; the next poll is accepted while it
// waits. If the receiver stalls longer, the following result holds in the
// sequencer and s_axis_tready stays low until the output register frees.
// Reset restores the register defaults, puts the cursor at 256,192 and clears the
// button, wheel and click history. Write configuration only while idle.
// Depends on pet_pkg, pet_alu, pet_seq and assert_macros.svh.
`include "assert_macros.svh"

module pointer_event_tracker_top #(
  parameter int unsigned CoordBits = pet_pkg::CoordBitsDef,
  localparam int unsigned OutDataW  = 4 + 2 * CoordBits,
  localparam int unsigned OutTdataW = ((OutDataW + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pet_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pet_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // left_down, right_down, move_x, move_y, move_z, now_ticks, zero pad
  input  logic [167:0]                   s_axis_tdata,
  // read_ok
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // event_code, pos_x, pos_y, zero pad
  output logic [OutTdataW-1:0]           m_axis_tdata
);

  pet_pkg::pet_cfg_t     cfg_q;
  pet_pkg::pet_alu_req_t alu_req;
  pet_pkg::pet_alu_rsp_t alu_rsp;

  logic                 res_valid, res_ready;
  pet_pkg::pet_event_e  res_event;
  logic [CoordBits-1:0] res_pos_x, res_pos_y;

  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width    <= pet_pkg::ScreenWidthRst;
      cfg_q.screen_height   <= pet_pkg::ScreenHeightRst;
      cfg_q.resolution_x    <= pet_pkg::ResolutionRst;
      cfg_q.resolution_y    <= pet_pkg::ResolutionRst;
      cfg_q.pointer_speed   <= pet_pkg::SpeedRst;
      cfg_q.mirror_x        <= 1'b0;
      cfg_q.double_click_ms <= pet_pkg::DoubleClickRst;
      cfg_q.ticks_per_ms    <= pet_pkg::TicksPerMsRst;
    end else if (cfg_we_i) begin
      unique case (pet_pkg::pet_reg_e'(cfg_idx_i))
        pet_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width    <= cfg_data_i[pet_pkg::SizeW-1:0];
        pet_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height   <= cfg_data_i[pet_pkg::SizeW-1:0];
        pet_pkg::REG_RESOLUTION_X:  cfg_q.resolution_x    <= cfg_data_i[pet_pkg::ResW-1:0];
        pet_pkg::REG_RESOLUTION_Y:  cfg_q.resolution_y    <= cfg_data_i[pet_pkg::ResW-1:0];
        pet_pkg::REG_POINTER_SPEED: cfg_q.pointer_speed   <= cfg_data_i[pet_pkg::SpeedW-1:0];
        pet_pkg::REG_MIRROR_X:      cfg_q.mirror_x        <= cfg_data_i[0];
        pet_pkg::REG_DOUBLE_CLICK:  cfg_q.double_click_ms <= cfg_data_i[pet_pkg::MsW-1:0];
        pet_pkg::REG_TICKS_PER_MS:  cfg_q.ticks_per_ms    <= cfg_data_i[pet_pkg::TpmW-1:0];
        default: ;
      endcase
    end
  end

  pet_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  pet_seq #(
    .CoordBits (CoordBits)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_read_ok_i (s_axis_tuser),
    .in_left_i    (s_axis_tdata[0]),
    .in_right_i   (s_axis_tdata[1]),
    .in_mx_i      ($signed(s_axis_tdata[33:2])),
    .in_my_i      ($signed(s_axis_tdata[65:34])),
    .in_mz_i      ($signed(s_axis_tdata[97:66])),
    .in_now_i     (s_axis_tdata[161:98]),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_event_o  (res_event),
    .res_pos_x_o  (res_pos_x),
    .res_pos_y_o  (res_pos_y)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {res_pos_y, res_pos_x, res_event};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(out_data_q);

  `PET_ASSERT_NEVER(a_ready_while_alu_busy, clk_i, rst_ni, s_axis_tready && alu_rsp.busy)
  `PET_ASSERT(a_result_lands, clk_i, rst_ni, (res_valid && res_ready) |=> m_axis_tvalid)
  `PET_ASSERT(a_failed_read_idle, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s_axis_tready)

endmodule

FILE: bench/pet_event_checker.sv
`timescale 1ns / 100ps
// Event checker for the pointer event tracker: watches the config port and both streams,
// predicts each result word from its own copy of state and registers, and compares.
// Depends on pet_pkg.
module pet_event_checker
  import pet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [167:0]        s_data_i,
  input  logic                s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [31:0]         m_data_i,
  output int unsigned         fails_o,
  output int unsigned         pending_o
);

  localparam int unsigned CoordW = CoordBitsDef;
  localparam longint CoordMax = (longint'(1) << CoordW) - 1;

  typedef struct packed {
    pet_event_e        ev;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } pointer_report_t;

  pet_cfg_t        regs;
  logic            left_q;
  logic            right_q;
  pet_wheel_e      wheel_q;
  logic            moved_q;
  logic [63:0]     click_ticks;
  longint          cur_x;
  longint          cur_y;
  pointer_report_t expected_reports[$];

  initial fails_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: ERROR %s: got %0d, expected %0d", $time, what, got, want);
    fails_o++;
  endtask

  function automatic longint scaled_delta(input logic [SizeW-1:0] size,
                                          input logic [31:0] mv,
                                          input logic [ResW-1:0] res,
                                          input logic [SpeedW-1:0] speed);
    longint q;
    if (res == '0) return 0;
    q = (longint'(size) * longint'($signed(mv))) / longint'(res);
    return (q * longint'(speed)) >>> SpeedShift;
  endfunction

  function automatic longint clamped(input longint pos, input logic [SizeW-1:0] size);
    longint lim;
    if (size == '0) return 0;
    lim = longint'(size) - 1;
    if (lim > CoordMax) lim = CoordMax;
    if (pos < 0) return 0;
    if (pos > lim) return lim;
    return pos;
  endfunction

  function automatic pointer_report_t track_poll(input logic [167:0] d);
    logic            l;
    logic            r;
    logic [31:0]     mx;
    logic [31:0]     my;
    logic [31:0]     mz;
    logic [63:0]     now;
    logic [63:0]     tick_div;
    logic [63:0]     elapsed;
    pet_event_e      ev;
    longint          dx;
    longint          dy;
    pointer_report_t rep;
    l   = d[0];
    r   = d[1];
    mx  = d[33:2];
    my  = d[65:34];
    mz  = d[97:66];
    now = d[161:98];
    if (!left_q && l) begin
      ev = EV_LEFT_DOWN;
    end else if (!right_q && r) begin
      ev = EV_RIGHT_DOWN;
    end else if (left_q && !l) begin
      tick_div = 64'(regs.ticks_per_ms) / 64'(TickScale);
      elapsed  = (tick_div != 0) ? (now - click_ticks) / tick_div : '1;
      ev = (elapsed < 64'(regs.double_click_ms)) ? EV_DOUBLE_CLICK : EV_LEFT_CLICK;
      click_ticks = now;
    end else if (right_q && !r) begin
      ev = EV_RIGHT_CLICK;
    end else if (wheel_q == WHEEL_POS) begin
      ev = EV_SCROLL_DOWN;
    end else if (wheel_q == WHEEL_NEG) begin
      ev = EV_SCROLL_UP;
    end else if (moved_q) begin
      ev = EV_MOVE;
    end else begin
      ev = EV_NONE;
    end
    left_q  = l;
    right_q = r;
    wheel_q = ($signed(mz) > 0) ? WHEEL_POS : (($signed(mz) < 0) ? WHEEL_NEG : WHEEL_NONE);
    moved_q = (mx != '0) || (my != '0);
    dx = scaled_delta(regs.screen_width, mx, regs.resolution_x, regs.pointer_speed);
    dy = scaled_delta(regs.screen_height, my, regs.resolution_y, regs.pointer_speed);
    cur_x = clamped(regs.mirror_x ? cur_x - dx : cur_x + dx, regs.screen_width);
    cur_y = clamped(cur_y + dy, regs.screen_height);
    rep.ev = ev;
    rep.x  = cur_x[CoordW-1:0];
    rep.y  = cur_y[CoordW-1:0];
    return rep;
  endfunction

  task automatic check_report(input logic [31:0] word);
    pointer_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("result word with none predicted", longint'(word), 0);
    end else begin
      want = expected_reports.pop_front();
      if (word[3:0] != want.ev)
        report_mismatch("event_code", longint'(word[3:0]), longint'(want.ev));
      if (word[4 +: CoordW] != want.x)
        report_mismatch("pos_x", longint'(word[4 +: CoordW]), longint'(want.x));
      if (word[4 + CoordW +: CoordW] != want.y)
        report_mismatch("pos_y", longint'(word[4 + CoordW +: CoordW]), longint'(want.y));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      regs.screen_width    = ScreenWidthRst;
      regs.screen_height   = ScreenHeightRst;
      regs.resolution_x    = ResolutionRst;
      regs.resolution_y    = ResolutionRst;
      regs.pointer_speed   = SpeedRst;
      regs.mirror_x        = 1'b0;
      regs.double_click_ms = DoubleClickRst;
      regs.ticks_per_ms    = TicksPerMsRst;
      left_q      = 1'b0;
      right_q     = 1'b0;
      wheel_q     = WHEEL_NONE;
      moved_q     = 1'b0;
      click_ticks = '0;
      cur_x       = longint'(CursorXRst);
      cur_y       = longint'(CursorYRst);
      expected_reports.delete();
    end else begin
      if (m_valid_i && m_ready_i) check_report(m_data_i);
      if (s_valid_i && s_ready_i && s_user_i) expected_reports.push_back(track_poll(s_data_i));
      if (cfg_we_i) begin
        case (pet_reg_e'(cfg_idx_i))
          REG_SCREEN_WIDTH:  regs.screen_width    = cfg_data_i[SizeW-1:0];
          REG_SCREEN_HEIGHT: regs.screen_height   = cfg_data_i[SizeW-1:0];
          REG_RESOLUTION_X:  regs.resolution_x    = cfg_data_i[ResW-1:0];
          REG_RESOLUTION_Y:  regs.resolution_y    = cfg_data_i[ResW-1:0];
          REG_POINTER_SPEED: regs.pointer_speed   = cfg_data_i[SpeedW-1:0];
          REG_MIRROR_X:      regs.mirror_x        = cfg_data_i[0];
          REG_DOUBLE_CLICK:  regs.double_click_ms = cfg_data_i[MsW-1:0];
          REG_TICKS_PER_MS:  regs.ticks_per_ms    = cfg_data_i[TpmW-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_reports.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top for the pointer event tracker: clock, reset, register writes, poll words
// and the verdict. Prediction and comparison live in pet_event_checker; uses pet_pkg.
module tb_top;
  import pet_pkg::*;

  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned SettleCycles  = 400;
  localparam int unsigned PollsPerPhase = 255;
  localparam int unsigned NumPhases     = 6;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // left_down, right_down, move_x, move_y, move_z, now_ticks, zero pad
  logic [167:0]        s_axis_tdata  = '0;
  // read_ok
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // event_code, pos_x, pos_y, zero pad
  logic [31:0]         m_axis_tdata;

  int unsigned fails;
  int unsigned pending;
  int unsigned tx_idle_pct  = 30;
  int unsigned rx_idle_pct  = 47;
  int unsigned stall_cycles = 0;

  pet_cfg_t    cur_cfg;
  pet_cfg_t    plan[NumPhases];
  logic        left_held  = 1'b0;
  logic        right_held = 1'b0;
  logic [63:0] now_ticks  = '0;

  pointer_event_tracker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pet_event_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .fails_o    (fails),
    .pending_o  (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("pointer_event_tracker_top: mismatch");
      $finish;
    end
  end

  function automatic pet_cfg_t make_cfg(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h,
                                        input logic [ResW-1:0] rx, input logic [ResW-1:0] ry,
                                        input logic [SpeedW-1:0] spd, input logic mir,
                                        input logic [MsW-1:0] dcms, input logic [TpmW-1:0] tpm);
    pet_cfg_t c;
    c.screen_width    = w;
    c.screen_height   = h;
    c.resolution_x    = rx;
    c.resolution_y    = ry;
    c.pointer_speed   = spd;
    c.mirror_x        = mir;
    c.double_click_ms = dcms;
    c.ticks_per_ms    = tpm;
    return c;
  endfunction

  task automatic put_reg(input pet_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input pet_cfg_t c);
    put_reg(REG_SCREEN_WIDTH,  CfgDataW'(c.screen_width));
    put_reg(REG_SCREEN_HEIGHT, CfgDataW'(c.screen_height));
    put_reg(REG_RESOLUTION_X,  CfgDataW'(c.resolution_x));
    put_reg(REG_RESOLUTION_Y,  CfgDataW'(c.resolution_y));
    put_reg(REG_POINTER_SPEED, CfgDataW'(c.pointer_speed));
    put_reg(REG_MIRROR_X,      CfgDataW'(c.mirror_x));
    put_reg(REG_DOUBLE_CLICK,  CfgDataW'(c.double_click_ms));
    put_reg(REG_TICKS_PER_MS,  CfgDataW'(c.ticks_per_ms));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_poll(input logic ok, input logic l, input logic r,
                           input logic [31:0] mx, input logic [31:0] my,
                           input logic [31:0] mz, input logic [63:0] now);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ok;
    s_axis_tdata  <= {6'd0, now, mz, my, mx, r, l};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_move();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return '0;
    if (pick < 8) return 32'($signed($urandom_range(600)) - 300);
    if (pick == 8) return 32'($signed($urandom_range(131070)) - 65535);
    return $urandom;
  endfunction

  task automatic random_polls(input int unsigned count);
    int unsigned good;
    logic [63:0] tick_div;
    good = 0;
    while (good < count) begin
      if ($urandom_range(19) == 0) begin
        send_poll(1'b0, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                  {$urandom, $urandom});
      end else begin
        tick_div = 64'(cur_cfg.ticks_per_ms) / 64'(TickScale);
        if (tick_div == 0) tick_div = 64'd1;
        if ($urandom_range(19) == 0) begin
          now_ticks = {$urandom, $urandom};
        end else begin
          now_ticks = now_ticks + 64'($urandom_range(2 * cur_cfg.double_click_ms + 2)) * tick_div
                      + 64'($urandom_range(7));
        end
        if ($urandom_range(2) == 0) left_held = ~left_held;
        if ($urandom_range(3) == 0) right_held = ~right_held;
        send_poll(1'b1, left_held, right_held, rand_move(), rand_move(), rand_move(), now_ticks);
        good++;
      end
    end
  endtask

  initial begin
    cur_cfg = make_cfg(ScreenWidthRst, ScreenHeightRst, ResolutionRst, ResolutionRst, SpeedRst,
                       1'b0, DoubleClickRst, TicksPerMsRst);
    plan[0] = make_cfg(14'd8192, 14'd8192, 16'd1, 16'd1, 16'hffff, 1'b1, 16'hffff, 32'hffff_ffff);
    plan[1] = make_cfg(14'd1, 14'd1, 16'hffff, 16'hffff, 16'd0, 1'b0, 16'd0, 32'd1);
    plan[2] = make_cfg(14'd0, 14'h3fff, 16'd0, 16'd3, 16'd1024, 1'b1, 16'd300, 32'd999);
    plan[3] = make_cfg(14'd800, 14'd600, 16'd400, 16'd400, 16'd3000, 1'b0, 16'd500, 32'd1000);
    plan[4] = make_cfg(SizeW'($urandom), SizeW'($urandom), ResW'($urandom), ResW'($urandom),
                       SpeedW'($urandom), 1'($urandom), MsW'($urandom_range(2000)),
                       TpmW'($urandom_range(5000000)));
    plan[5] = cur_cfg;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // button edges, both click kinds around the window edge, scroll, move, idle read
    send_poll(1'b0, 1'b1, 1'b1, '1, '1, '1, '1);
    send_poll(1'b1, 1'b1, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'd5, 64'd100);
    send_poll(1'b1, 1'b1, 1'b0, '0, '0, 32'hffff_fffd, 64'd200);
    send_poll(1'b1, 1'b1, 1'b1, '0, '0, '0, 64'd300);
    send_poll(1'b1, 1'b0, 1'b1, 32'd10, 32'hffff_fff6, '0, 64'd400000);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, 64'd500000);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, 32'hffff_ffff, 64'd510000);
    send_poll(1'b1, 1'b0, 1'b0, 32'd3, '0, '0, 64'd520000);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, 64'd530000);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, 64'd540000);
    send_poll(1'b1, 1'b1, 1'b0, '0, '0, '0, 64'd600000);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, 64'd1100000);
    send_poll(1'b1, 1'b1, 1'b0, '0, 32'd7, '0, 64'd1100500);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, 64'd1599999);
    send_poll(1'b1, 1'b1, 1'b0, '0, '0, '0, 64'd1);
    // timestamp going backwards wraps
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, 64'd0);
    send_poll(1'b1, 1'b1, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, '1);
    send_poll(1'b1, 1'b0, 1'b0, 32'hffff_ffff, 32'd1, 32'h8000_0000, '1);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, '1);
    send_poll(1'b0, 1'b0, 1'b0, '0, '0, '0, '0);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, '0);
    send_poll(1'b1, 1'b0, 1'b0, '0, '0, '0, 64'd10);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      if (phase == 2) begin
        tx_idle_pct = 47;
        rx_idle_pct = 30;
      end else if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cur_cfg = plan[phase];
      load_regs(cur_cfg);
      random_polls(PollsPerPhase);
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("pointer_event_tracker_top: match");
    end else begin
      $display("pointer_event_tracker_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/pet_pkg.sv
rtl/pet_alu.sv
rtl/pet_seq.sv
rtl/pointer_event_tracker_top.sv
bench/pet_event_checker.sv
bench/tb_top.sv
